// File: design/gated_touch_frequency_classifier_unit_macros.svh
// Assertion macros shared by the classifier's checker.
`ifndef GATED_TOUCH_FREQUENCY_CLASSIFIER_UNIT_MACROS_SVH
`define GATED_TOUCH_FREQUENCY_CLASSIFIER_UNIT_MACROS_SVH

// Check that an implication holds at every rising edge outside reset.
`define GTFC_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gtfc assertion failed");

// Check that a condition never shows outside reset.
`define GTFC_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("gtfc forbidden condition seen");

`endif

// File: design/gtfc_pkg.sv
// Types and constants shared by the gated touch frequency classifier.
package gtfc_pkg;

    localparam int FREQ_W   = 18;
    localparam int TOL_W    = 16;
    localparam int MS_W     = 8;
    localparam int ACC_W    = 16;
    localparam int DWELL_W  = 16;
    localparam int TOUCH_W  = 16;
    localparam int NUM_W    = 26;   // edge sum times 1000
    localparam int CFG_W    = 18;
    localparam int IDX_W    = 4;
    localparam int DWELL_WIDTH_DEF = 16;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_NEUTRAL   = 4'd0;
    localparam logic [IDX_W-1:0] REG_VALID_A   = 4'd1;
    localparam logic [IDX_W-1:0] REG_VALID_B   = 4'd2;
    localparam logic [IDX_W-1:0] REG_TOLERANCE = 4'd3;
    localparam logic [IDX_W-1:0] REG_BLANK     = 4'd4;
    localparam logic [IDX_W-1:0] REG_WINDOW    = 4'd5;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE  = 4'd6;
    localparam logic [IDX_W-1:0] REG_MIN_DWELL = 4'd7;

    typedef logic [2:0] t_band;
    localparam t_band BAND_BLANK   = 3'd0;
    localparam t_band BAND_NEUTRAL = 3'd1;
    localparam t_band BAND_VALID_A = 3'd2;
    localparam t_band BAND_VALID_B = 3'd3;
    localparam t_band BAND_UNKNOWN = 3'd4;

    typedef struct packed {
        logic [FREQ_W-1:0] neutral_freq;
        logic [FREQ_W-1:0] valid_a_freq;
        logic [FREQ_W-1:0] valid_b_freq;
        logic [TOL_W-1:0]  band_tolerance;
        logic [TOL_W-1:0]  blank_limit;
    } t_band_cfg;

    // Snapshot of a finished touch handed from the front end
    typedef struct packed {
        logic [ACC_W-1:0]   edges;
        logic [MS_W-1:0]    ms;
        logic [DWELL_W-1:0] dwell;
        logic [TOUCH_W-1:0] touch;
    } t_job;

endpackage

// File: design/gated_touch_frequency_classifier_unit.sv
// Top level of the gated touch frequency classifier.
//
//  channel  | direction | signals                          | beat carries
//  ---------+-----------+----------------------------------+---------------------------
//  s_axis   | in        | tvalid, tready, tdata[15:0]      | one millisecond sample
//  m_axis   | out       | tvalid, tready, tdata[55:0]      | one finished touch
//  cfg      | in        | i_cfg_valid, o_cfg_ready, index  | one register write
//
// A sample that does not end a touch leaves tready high.
// After a release beat tready drops while the job is loaded, the bit-serial
// divider forms its 26 quotient bits, one to four band checks run and the
// output register is loaded.
// A held result beat stalls a later release in the output state until it frees.
// Reset is synchronous, active low; configuration returns to its defaults.
module gated_touch_frequency_classifier_unit #(
    parameter int DWELL_WIDTH = gtfc_pkg::DWELL_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // sample stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,   // [0] raw_pressed, [8:1] edge_count
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [55:0]                 m_axis_tdata,   // [17:0] freq_hz, [20:18] band_class,
                                                        // [36:21] dwell_ms, [37] dwell_short,
                                                        // [53:38] touch_number
    // register writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gtfc_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [gtfc_pkg::CFG_W-1:0]  i_cfg_data
);
    import gtfc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_CLS  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]         r_state;
    logic               r_out_valid;
    logic [55:0]        r_out_data;

    t_band_cfg          r_band_cfg;
    logic [MS_W-1:0]    r_window_ms;
    logic [MS_W-1:0]    r_debounce_ms;
    logic [DWELL_W-1:0] r_min_dwell;

    logic               w_in_beat;
    logic               w_out_free;
    logic               w_release;
    t_job               w_job;
    logic               w_div_done;
    logic [FREQ_W-1:0]  w_div_freq;
    logic               w_cls_done;
    logic [FREQ_W-1:0]  w_cls_freq;
    t_band              w_cls_band;
    logic               w_short;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_cfg.neutral_freq   <= FREQ_W'(20000);
            r_band_cfg.valid_a_freq   <= FREQ_W'(25000);
            r_band_cfg.valid_b_freq   <= FREQ_W'(40000);
            r_band_cfg.band_tolerance <= TOL_W'(2000);
            r_band_cfg.blank_limit    <= TOL_W'(500);
            r_window_ms               <= MS_W'(50);
            r_debounce_ms             <= MS_W'(5);
            r_min_dwell               <= DWELL_W'(15);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NEUTRAL:   r_band_cfg.neutral_freq   <= i_cfg_data;
                REG_VALID_A:   r_band_cfg.valid_a_freq   <= i_cfg_data;
                REG_VALID_B:   r_band_cfg.valid_b_freq   <= i_cfg_data;
                REG_TOLERANCE: r_band_cfg.band_tolerance <= i_cfg_data[TOL_W-1:0];
                REG_BLANK:     r_band_cfg.blank_limit    <= i_cfg_data[TOL_W-1:0];
                REG_WINDOW:    r_window_ms               <= i_cfg_data[MS_W-1:0];
                REG_DEBOUNCE:  r_debounce_ms             <= i_cfg_data[MS_W-1:0];
                REG_MIN_DWELL: r_min_dwell               <= i_cfg_data[DWELL_W-1:0];
                default: ;
            endcase
        end
    end

    gtfc_frontend #(
        .DWELL_W (DWELL_WIDTH)
    ) u_frontend (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat        (w_in_beat),
        .i_raw         (s_axis_tdata[0]),
        .i_edges       (s_axis_tdata[8:1]),
        .i_debounce_ms (r_debounce_ms),
        .i_window_ms   (r_window_ms),
        .o_release     (w_release),
        .o_job         (w_job)
    );

    gtfc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_LOAD),
        .i_edges (w_job.edges),
        .i_ms    (w_job.ms),
        .o_done  (w_div_done),
        .o_freq  (w_div_freq)
    );

    gtfc_classifier u_classifier (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_done),
        .i_freq  (w_div_freq),
        .i_cfg   (r_band_cfg),
        .o_done  (w_cls_done),
        .o_freq  (w_cls_freq),
        .o_band  (w_cls_band)
    );

    assign w_short = (w_job.dwell < r_min_dwell);

    // Sequencer: a release walks load, divide, classify, then output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: if (w_release)  r_state <= ST_LOAD;
                ST_LOAD:                 r_state <= ST_DIV;
                ST_DIV:  if (w_div_done) r_state <= ST_CLS;
                ST_CLS:  if (w_cls_done) r_state <= ST_OUT;
                ST_OUT:  if (w_out_free) r_state <= ST_IDLE;
                default:                 r_state <= ST_IDLE;
            endcase
        end
    end

    // Output register: hold the beat until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            r_out_data <= {2'b00, w_job.touch, w_short, w_job.dwell,
                           w_cls_band, w_cls_freq};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: design/gtfc_frontend.sv
// Debounce, window accumulation, dwell and touch counting, one item per beat.
module gtfc_frontend #(
    parameter int DWELL_W = gtfc_pkg::DWELL_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_beat,
    input  logic                     i_raw,
    input  logic [7:0]               i_edges,
    input  logic [gtfc_pkg::MS_W-1:0] i_debounce_ms,
    input  logic [gtfc_pkg::MS_W-1:0] i_window_ms,
    output logic                     o_release,
    output gtfc_pkg::t_job           o_job
);
    import gtfc_pkg::*;

    logic               r_last_raw;
    logic [MS_W-1:0]    r_stable;
    logic               r_pressed;
    logic [ACC_W-1:0]   r_acc;
    logic [MS_W-1:0]    r_elapsed;
    logic [DWELL_W-1:0] r_dwell;
    logic [TOUCH_W-1:0] r_touches;
    t_job               r_job;

    logic [MS_W-1:0]    n_stable;
    logic               n_deb;
    logic [ACC_W:0]     w_sum;
    logic [ACC_W-1:0]   w_acc_inc;
    logic [MS_W-1:0]    w_elapsed_inc;
    logic [DWELL_W-1:0] w_dwell_inc;
    logic [31:0]        w_dwell_ext;
    logic [MS_W-1:0]    w_win;
    logic               w_release;
    logic               w_win_end;

    always_comb begin
        if (i_raw != r_last_raw) begin
            n_stable = '0;
        end else if (r_stable != '1) begin
            n_stable = r_stable + 1'b1;
        end else begin
            n_stable = r_stable;
        end
        n_deb = (n_stable >= i_debounce_ms) ? i_raw : r_pressed;

        w_sum         = {1'b0, r_acc} + {{(ACC_W + 1 - 8){1'b0}}, i_edges};
        w_acc_inc     = w_sum[ACC_W] ? '1 : w_sum[ACC_W-1:0];
        w_elapsed_inc = (r_elapsed != '1) ? r_elapsed + 1'b1 : r_elapsed;
        w_dwell_inc   = (r_dwell != '1) ? r_dwell + 1'b1 : r_dwell;
        w_dwell_ext   = 32'(w_dwell_inc);
        w_win         = (i_window_ms == '0) ? MS_W'(1) : i_window_ms;
        w_win_end     = (w_elapsed_inc >= w_win);
        w_release     = i_beat && r_pressed && !n_deb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw <= 1'b0;
            r_stable   <= '0;
            r_pressed  <= 1'b0;
            r_acc      <= '0;
            r_elapsed  <= '0;
            r_dwell    <= '0;
            r_touches  <= '0;
        end else if (i_beat) begin
            r_last_raw <= i_raw;
            r_stable   <= n_stable;
            r_pressed  <= n_deb;
            if (r_pressed && !n_deb) begin
                // release: close the partial window
                r_acc     <= '0;
                r_elapsed <= '0;
                r_dwell   <= w_dwell_inc;
                r_touches <= r_touches + 1'b1;
            end else if (r_pressed) begin
                r_dwell <= w_dwell_inc;
                if (w_win_end) begin
                    r_acc     <= '0;
                    r_elapsed <= '0;
                end else begin
                    r_acc     <= w_acc_inc;
                    r_elapsed <= w_elapsed_inc;
                end
            end else if (n_deb) begin
                // press: drop this millisecond's edges and restart
                r_acc     <= '0;
                r_elapsed <= '0;
                r_dwell   <= '0;
            end
        end
    end

    // Job snapshot holds until the next release
    always_ff @(posedge i_clk) begin
        if (w_release) begin
            r_job.edges <= w_acc_inc;
            r_job.ms    <= w_elapsed_inc;
            r_job.dwell <= (w_dwell_ext[31:16] != '0) ? '1 : w_dwell_ext[15:0];
            r_job.touch <= r_touches + 1'b1;
        end
    end

    assign o_release = w_release;
    assign o_job     = r_job;

endmodule

// File: design/gtfc_divider.sv
// Bit-serial restoring divider: edges times 1000 over elapsed milliseconds.
module gtfc_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gtfc_pkg::ACC_W-1:0]  i_edges,
    input  logic [gtfc_pkg::MS_W-1:0]   i_ms,
    output logic                        o_done,
    output logic [gtfc_pkg::FREQ_W-1:0] o_freq
);
    import gtfc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;    // numerator in, quotient out
    logic [MS_W-1:0]  r_rem;
    logic [MS_W-1:0]  r_div;

    logic [MS_W:0]    w_trial;
    logic [MS_W:0]    w_diff;
    logic             w_ge;
    logic [NUM_W-1:0] w_load;

    always_comb begin
        // x * 1000 = x * 1024 - x * 16 - x * 8
        w_load  = (NUM_W'(i_edges) << 10) - (NUM_W'(i_edges) << 4)
                  - (NUM_W'(i_edges) << 3);
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= w_load;
            r_rem <= '0;
            r_div <= i_ms;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[MS_W-1:0] : w_trial[MS_W-1:0];
        end
    end

    assign o_done = r_done;
    // saturate at the top of the frequency range
    assign o_freq = (r_num[NUM_W-1:FREQ_W] != '0) ? '1 : r_num[FREQ_W-1:0];

endmodule

// File: design/gtfc_classifier.sv
// Serial band check: blank, then one band per cycle in priority order.
module gtfc_classifier (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gtfc_pkg::FREQ_W-1:0] i_freq,
    input  gtfc_pkg::t_band_cfg         i_cfg,
    output logic                        o_done,
    output logic [gtfc_pkg::FREQ_W-1:0] o_freq,
    output gtfc_pkg::t_band             o_band
);
    import gtfc_pkg::*;

    localparam logic [1:0] STEP_BLANK   = 2'd0;
    localparam logic [1:0] STEP_NEUTRAL = 2'd1;
    localparam logic [1:0] STEP_VALID_A = 2'd2;
    localparam logic [1:0] STEP_VALID_B = 2'd3;

    logic              r_busy;
    logic              r_done;
    logic [1:0]        r_step;
    logic [FREQ_W-1:0] r_freq;
    t_band             r_band;

    logic [FREQ_W-1:0] w_centre;
    logic [FREQ_W-1:0] w_lo;
    logic [FREQ_W:0]   w_hi;
    logic              w_hit;
    t_band             w_class;

    always_comb begin
        unique case (r_step)
            STEP_NEUTRAL: begin
                w_centre = i_cfg.neutral_freq;
                w_class  = BAND_NEUTRAL;
            end
            STEP_VALID_A: begin
                w_centre = i_cfg.valid_a_freq;
                w_class  = BAND_VALID_A;
            end
            STEP_VALID_B: begin
                w_centre = i_cfg.valid_b_freq;
                w_class  = BAND_VALID_B;
            end
            default: begin
                w_centre = '0;
                w_class  = BAND_BLANK;
            end
        endcase
        // lower bound saturates at zero, upper bound does not wrap
        w_lo = (w_centre > FREQ_W'(i_cfg.band_tolerance))
               ? w_centre - FREQ_W'(i_cfg.band_tolerance) : '0;
        w_hi = {1'b0, w_centre} + (FREQ_W + 1)'(i_cfg.band_tolerance);
        if (r_step == STEP_BLANK) begin
            w_hit = (r_freq < FREQ_W'(i_cfg.blank_limit));
        end else begin
            w_hit = (r_freq >= w_lo) && ({1'b0, r_freq} <= w_hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_BLANK;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_BLANK;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (w_hit || r_step == STEP_VALID_B) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_freq <= i_freq;
        end
        if (r_busy) begin
            r_band <= w_hit ? w_class : BAND_UNKNOWN;
        end
    end

    assign o_done = r_done;
    assign o_freq = r_freq;
    assign o_band = r_band;

endmodule

// File: design/gtfc_checker.sv
// Port-level checker for the classifier and its bind to the top level.
`include "gated_touch_frequency_classifier_unit_macros.svh"

module gtfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    // a stalled result beat holds
    `GTFC_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // a new result only appears after the input side was stalled for the divide
    `GTFC_ASSERT_IMPL(a_result_after_stall, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(!s_axis_tready))

    // the input side only stalls right after a taken sample beat
    `GTFC_ASSERT_IMPL(a_stall_after_beat, i_clk, i_rst_n, $fell(s_axis_tready) |-> $past(s_axis_tvalid))

    // band class stays within its five codes
    `GTFC_ASSERT_NEVER(a_band_range, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[20:18] > 3'd4))

endmodule

bind gated_touch_frequency_classifier_unit gtfc_checker u_gtfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: bench/testbench.sv
// Self-checking bench for the gated touch frequency classifier: streams, registers, prediction.
module testbench;
    import gtfc_pkg::*;

    // Indexes past the last register; writes there must leave every register alone.
    localparam logic [IDX_W-1:0] REG_FIRST_UNUSED = 4'd8;
    // Quiet cycles allowed before the run is declared hung. The limit covers a release,
    // a receiver stall, a sender gap and a settle.
    localparam int unsigned QUIET_LIMIT = 2000;
    // Cycles to wait after the last result before touching registers or ending.
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned PRINT_LIMIT = 100;

    typedef struct {
        logic [FREQ_W-1:0]  freq_hz;
        t_band              band_class;
        logic [DWELL_W-1:0] dwell_ms;
        logic               dwell_short;
        logic [TOUCH_W-1:0] touch_number;
    } t_touch_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata = '0;   // [0] raw_pressed, [8:1] edge_count
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [55:0]        m_axis_tdata;        // [17:0] freq_hz, [20:18] band_class,
                                             // [36:21] dwell_ms, [37] dwell_short,
                                             // [53:38] touch_number
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;

    gated_touch_frequency_classifier_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predicted copy of the register file, at reset values.
    // ------------------------------------------------------------------
    int unsigned cfg_neutral   = 20000;
    int unsigned cfg_valid_a   = 25000;
    int unsigned cfg_valid_b   = 40000;
    int unsigned cfg_tolerance = 2000;
    int unsigned cfg_blank     = 500;
    int unsigned cfg_window    = 50;
    int unsigned cfg_debounce  = 5;
    int unsigned cfg_min_dwell = 15;

    // Predicted debounce, window and touch state, all cleared by reset.
    int unsigned last_level   = 0;
    int unsigned level_stable = 0;   // ms since the raw level last changed, saturating
    int unsigned touch_down   = 0;   // debounced pressed level
    int unsigned edge_sum     = 0;
    int unsigned window_span  = 0;   // ms in the open window
    int unsigned freq_latest  = 0;
    int unsigned dwell_run    = 0;
    int unsigned touch_total  = 0;

    t_touch_result touches_due[$];   // finished touches still to appear on m_axis

    int unsigned mismatches   = 0;
    int unsigned items_sent   = 0;
    int unsigned quiet_cycles = 0;
    bit          gaps_on      = 1'b1;

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("ERROR @%0t: %s", $time, what);
    endtask

    // Mirror a register write; only the register's own width is kept.
    task automatic apply_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        case (idx)
            REG_NEUTRAL:   cfg_neutral   = value;
            REG_VALID_A:   cfg_valid_a   = value;
            REG_VALID_B:   cfg_valid_b   = value;
            REG_TOLERANCE: cfg_tolerance = value[15:0];
            REG_BLANK:     cfg_blank     = value[15:0];
            REG_WINDOW:    cfg_window    = value[7:0];
            REG_DEBOUNCE:  cfg_debounce  = value[7:0];
            REG_MIN_DWELL: cfg_min_dwell = value[15:0];
            default: ;
        endcase
    endtask

    // Edges over a window in hertz, saturating at the field's top.
    function automatic int unsigned window_hertz(input int unsigned sum, input int unsigned ms);
        longint unsigned f;
        f = sum;
        f = (f * 1000) / ms;
        return (f > 262143) ? 262143 : int'(f);
    endfunction

    // Inclusive band around a centre; the low bound stops at zero, the high one never wraps.
    function automatic bit falls_in_band(input int unsigned f, input int unsigned centre);
        int unsigned lo;
        lo = (centre > cfg_tolerance) ? centre - cfg_tolerance : 0;
        return (f >= lo) && (f <= centre + cfg_tolerance);
    endfunction

    function automatic t_band classify_band(input int unsigned f);
        if (f < cfg_blank)                  return BAND_BLANK;
        if (falls_in_band(f, cfg_neutral))  return BAND_NEUTRAL;
        if (falls_in_band(f, cfg_valid_a))  return BAND_VALID_A;
        if (falls_in_band(f, cfg_valid_b))  return BAND_VALID_B;
        return BAND_UNKNOWN;
    endfunction

    // Advance the predicted state by one accepted millisecond; queue a touch on release.
    task automatic track_millisecond(input logic raw, input logic [7:0] edges);
        int unsigned   settled;
        int unsigned   span_limit;
        t_touch_result done;
        span_limit = (cfg_window == 0) ? 1 : cfg_window;
        if (raw != last_level)
            level_stable = 0;
        else if (level_stable < 255)
            level_stable++;
        last_level = raw;
        settled = (level_stable >= cfg_debounce) ? raw : touch_down;

        // The millisecond that recognizes the press contributes nothing.
        if (touch_down != 0) begin
            if (dwell_run < 65535) dwell_run++;
            if (window_span < 255) window_span++;
            edge_sum = edge_sum + edges;
            if (edge_sum > 65535) edge_sum = 65535;
        end

        if (touch_down != 0 && settled == 0) begin
            // Release: close the partial window and report the touch.
            if (window_span > 0) freq_latest = window_hertz(edge_sum, window_span);
            edge_sum    = 0;
            window_span = 0;
            touch_total = (touch_total + 1) & 16'hFFFF;
            done.freq_hz      = FREQ_W'(freq_latest);
            done.band_class   = classify_band(freq_latest);
            done.dwell_ms     = DWELL_W'(dwell_run);
            done.dwell_short  = (dwell_run < cfg_min_dwell);
            done.touch_number = TOUCH_W'(touch_total);
            touches_due.push_back(done);
        end else if (touch_down != 0) begin
            if (window_span > 0 && window_span >= span_limit) begin
                freq_latest = window_hertz(edge_sum, window_span);
                edge_sum    = 0;
                window_span = 0;
            end
        end else if (settled != 0) begin
            edge_sum    = 0;
            window_span = 0;
            dwell_run   = 0;
        end
        touch_down = settled;
    endtask

    // ------------------------------------------------------------------
    // Sample at the rising edge: check result beats first, then mirror
    // register writes and accepted samples into the prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_beats
        t_touch_result want;
        logic [55:0]   got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (touches_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result beat %h", got));
                end else begin
                    want = touches_due.pop_front();
                    if (got[17:0] !== want.freq_hz)
                        flag_mismatch($sformatf("touch %0d freq_hz %0d, want %0d",
                            want.touch_number, got[17:0], want.freq_hz));
                    if (got[20:18] !== want.band_class)
                        flag_mismatch($sformatf("touch %0d band_class %0d, want %0d",
                            want.touch_number, got[20:18], want.band_class));
                    if (got[36:21] !== want.dwell_ms)
                        flag_mismatch($sformatf("touch %0d dwell_ms %0d, want %0d",
                            want.touch_number, got[36:21], want.dwell_ms));
                    if (got[37] !== want.dwell_short)
                        flag_mismatch($sformatf("touch %0d dwell_short %b, want %b",
                            want.touch_number, got[37], want.dwell_short));
                    if (got[53:38] !== want.touch_number)
                        flag_mismatch($sformatf("touch_number %0d, want %0d",
                            got[53:38], want.touch_number));
                    if (got[55:54] !== 2'b00)
                        flag_mismatch($sformatf("touch %0d padding bits %b",
                            want.touch_number, got[55:54]));
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                apply_register(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                track_millisecond(s_axis_tdata[0], s_axis_tdata[8:1]);
        end
    end

    // Count cycles with no beat on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("ERROR @%0t: no beat for %0d cycles, %0d touches outstanding",
                 $time, QUIET_LIMIT, touches_due.size());
        $display("Mismatches found");
        $finish;
    end

    // Result side back-pressure: long ready stretches, short flickers, rare long stalls.
    int unsigned ready_hold = 0;
    always @(negedge i_clk) begin : drive_ready
        int unsigned pick;
        if (ready_hold != 0) begin
            ready_hold--;
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                m_axis_tready <= 1'b1;
                ready_hold = $urandom_range(20, 200);
            end else if (pick < 6) begin
                m_axis_tready <= 1'b1;
                ready_hold = $urandom_range(0, 3);
            end else if (pick < 9) begin
                m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(20, 60);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side. Every task starts and ends at a falling edge.
    // ------------------------------------------------------------------
    function automatic int unsigned sender_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (!gaps_on || pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Send one millisecond sample; valid stays high into the next beat unless a gap follows.
    task automatic send_ms(input logic raw, input logic [7:0] edges);
        int unsigned gap;
        gap = sender_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, edges, raw};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Hold the sender until every predicted touch has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (touches_due.size() != 0) @(negedge i_clk);
    endtask

    // Drain, then let a late release finish its division before registers change.
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_registers(input logic [CFG_W-1:0] neutral, valid_a, valid_b,
                                  tolerance, blank, window, debounce, min_dwell);
        write_register(REG_NEUTRAL,   neutral);
        write_register(REG_VALID_A,   valid_a);
        write_register(REG_VALID_B,   valid_b);
        write_register(REG_TOLERANCE, tolerance);
        write_register(REG_BLANK,     blank);
        write_register(REG_WINDOW,    window);
        write_register(REG_DEBOUNCE,  debounce);
        write_register(REG_MIN_DWELL, min_dwell);
    endtask

    // Random value for a 16-bit register; the two spare data bits toggle too.
    function automatic logic [CFG_W-1:0] wide16(input int unsigned lo, input int unsigned hi);
        return {$urandom_range(0, 3) == 0 ? 2'($urandom) : 2'b00, 16'($urandom_range(lo, hi))};
    endfunction

    function automatic logic [CFG_W-1:0] random_centre();
        if ($urandom_range(0, 1) == 0)
            return CFG_W'($urandom_range(0, 60) * 1000 + $urandom_range(0, 999));
        return CFG_W'($urandom_range(0, 262143));
    endfunction

    task automatic randomize_registers();
        int unsigned pick;
        logic [CFG_W-1:0] window, debounce;
        pick = $urandom_range(0, 7);
        window = (pick == 0) ? CFG_W'(0) : (pick == 1) ? CFG_W'(255)
               : (pick == 2) ? CFG_W'($urandom_range(0, 255)) : CFG_W'($urandom_range(1, 20));
        debounce = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(7, 40))
                                               : CFG_W'($urandom_range(0, 6));
        load_registers(random_centre(), random_centre(), random_centre(),
                       ($urandom_range(0, 7) == 0) ? wide16(0, 65535) : wide16(0, 4000),
                       ($urandom_range(0, 7) == 0) ? wide16(0, 65535) : wide16(0, 3000),
                       window, debounce,
                       ($urandom_range(0, 7) == 0) ? wide16(0, 65535) : wide16(0, 80));
        // Stray writes to unused indexes now and then.
        if ($urandom_range(0, 3) == 0)
            write_register(IDX_W'($urandom_range(REG_FIRST_UNUSED, 15)),
                           CFG_W'($urandom_range(0, 262143)));
    endtask

    // Edge rate per ms that lands near one of the configured bands, or anywhere.
    function automatic int unsigned pick_rate();
        int unsigned centre, lo, hi;
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 255);
            1: return 0;
            2: centre = cfg_neutral;
            3: centre = cfg_valid_a;
            default: centre = cfg_valid_b;
        endcase
        lo = ((centre > cfg_tolerance) ? centre - cfg_tolerance : 0) / 1000;
        hi = (centre + cfg_tolerance) / 1000 + 1;
        if (lo > 255) lo = 255;
        if (hi > 255) hi = 255;
        return $urandom_range(lo, hi);
    endfunction

    // Edges for one ms of a tone: the rate with a little jitter, sometimes pure noise.
    function automatic logic [7:0] tone_edges(input int unsigned rate);
        int v;
        if ($urandom_range(0, 15) == 0) return 8'($urandom);
        v = int'(rate) + int'($urandom_range(0, 2)) - 1;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    // One touch: idle, contact bounce, a held press with an optional dropout, release.
    task automatic random_touch(input int unsigned debounce);
        int unsigned rate, idle_len, press_len, dropout_at, bounce_max, k;
        rate = pick_rate();
        bounce_max = (debounce == 0) ? 1 : (debounce > 6) ? 6 : debounce;
        // Idle, now and then long enough to saturate the stability count.
        idle_len = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 300)
                                                : $urandom_range(0, debounce + 3);
        repeat (idle_len) send_ms(1'b0, 8'($urandom));
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(1, bounce_max)) send_ms(1'b1, 8'($urandom));
                repeat ($urandom_range(1, bounce_max)) send_ms(1'b0, 8'($urandom));
            end
        end
        press_len = debounce + 1 + (($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
                                                                 : $urandom_range(0, 40));
        // Some presses end before the debounce accepts them.
        if ($urandom_range(0, 7) == 0) press_len = $urandom_range(1, debounce + 1);
        dropout_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, press_len) : 0;
        for (k = 1; k <= press_len; k++) begin
            if (k == dropout_at)
                repeat ($urandom_range(1, bounce_max)) send_ms(1'b0, tone_edges(rate));
            send_ms(1'b1, tone_edges(rate));
        end
        repeat (debounce + 1 + $urandom_range(0, 3)) send_ms(1'b0, tone_edges(rate));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Instant debounce and one-ms windows: a two-beat touch measures the release
    // ms alone, so its edge count times 1000 walks every band boundary. The
    // press ms carries edges that must be dropped.
    task automatic test_band_bounds();
        logic [7:0] release_edges[8] = '{8'd2, 8'd19, 8'd21, 8'd22, 8'd24, 8'd39, 8'd41, 8'd255};
        int i;
        load_registers(20000, 23000, 40000, 1000, 3000, 1, 0, 15);
        for (i = 0; i < 8; i++) begin
            send_ms(1'b1, (i % 2 == 0) ? 8'd255 : 8'd0);
            send_ms(1'b0, release_edges[i]);
        end
        settle();
    endtask

    // Unused indexes, oversized data for narrow registers, a zero window, a band
    // whose low bound saturates at zero, and dwell on both sides of its minimum.
    task automatic test_register_writes();
        int i;
        for (i = REG_FIRST_UNUSED; i < 16; i++)
            write_register(IDX_W'(i), CFG_W'($urandom_range(0, 262143)));
        load_registers(2000, 100000, 200000, 18'h30BB8, 18'h30000, 18'h3FF00, 18'h3FF00,
                       18'h20002);
        send_ms(1'b1, 8'd255);
        send_ms(1'b0, 8'd0);     // zero hertz falls in the neutral band
        send_ms(1'b1, 8'd9);
        send_ms(1'b1, 8'd5);     // closes a window at once
        send_ms(1'b0, 8'd5);     // upper band bound, dwell equal to the minimum
        settle();
    endtask

    // Random touches over changing settings; first all registers at their top,
    // then at their bottom, then random.
    task automatic test_random_touches();
        int unsigned first_item, phase;
        first_item = items_sent;
        phase = 0;
        while (items_sent - first_item < 1450) begin
            settle();
            if (phase == 0)
                load_registers(18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'hFFFF, 18'hFFFF,
                               255, 255, 18'hFFFF);
            else if (phase == 1)
                load_registers(0, 0, 0, 0, 0, 0, 0, 0);
            else
                randomize_registers();
            gaps_on = (phase % 4 != 3);
            repeat ((phase == 0) ? 1 : 6) begin
                random_touch(cfg_debounce);
                if ($urandom_range(0, 9) == 0) drain_results();
            end
            phase++;
        end
        gaps_on = 1'b1;
        settle();
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_band_bounds();
        test_register_writes();
        test_random_touches();

        // settle() above has drained everything; anything left is a miss.
        if (touches_due.size() != 0)
            flag_mismatch($sformatf("%0d touches never came out", touches_due.size()));
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: gated_touch_frequency_classifier_unit.f
+incdir+design
design/gtfc_pkg.sv
design/gtfc_frontend.sv
design/gtfc_divider.sv
design/gtfc_classifier.sv
design/gated_touch_frequency_classifier_unit.sv
design/gtfc_checker.sv
bench/testbench.sv
